@@ rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the circular deque
// no dependencies

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NOP        = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] popped;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] head_word;
    logic signed [DATA_W-1:0] tail_word;
  } result_word_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

endpackage

@@ rtl/cdq_ram.sv @@
`timescale 1ns / 1ps
// single-port-write, single-port-read synchronous ram with a registered read
// standalone, no package needed

module cdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/circular_deque.sv @@
`timescale 1ns / 1ps
// circular deque: DEPTH signed words in a synchronous ram, front and rear words cached
// an accepted command moves the deque to ST_RESP, which registers the result and raises done;
//   done is high for one cycle, and the receiver takes the result at the edge that ends it
// a new command is not accepted while busy; busy is high for the cycle in which
//   the ram read for a pop returns and the result is formed
// the receiver cannot stall; reset (rst, synchronous) empties the deque, ram is not cleared
// depends on cdq_pkg and cdq_ram

module circular_deque
  import cdq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  cmd_word_t    item,
  output logic         done,
  output result_word_t result
);

  state_t state;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty, empty_next;

  logic signed [DATA_W-1:0] front_word, front_next;
  logic signed [DATA_W-1:0] rear_word, rear_next;

  logic                     ok, ok_next;
  logic signed [DATA_W-1:0] popped, popped_next;
  logic                     load_front, load_front_next;
  logic                     load_rear, load_rear_next;

  logic              accept;
  logic              full;
  logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;

  logic signed [DATA_W-1:0] head_view, tail_view;
  logic                     full_now;

  cdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state == ST_RESP);
  assign accept = start && !busy;

  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign full     = !empty && (tail_inc == head);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    empty_next      = empty;
    front_next      = front_word;
    rear_next       = rear_word;
    ok_next         = 1'b0;
    popped_next     = '0;
    load_front_next = 1'b0;
    load_rear_next  = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    re              = 1'b0;
    raddr           = '0;
    if (accept) begin
      unique case (item.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (!full) begin
            ok_next = 1'b1;
            we      = 1'b1;
            if (empty) begin
              // first word goes to entry zero
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b0;
              waddr      = '0;
              front_next = item.value;
              rear_next  = item.value;
            end else if (item.cmd == CMD_PUSH_FRONT) begin
              head_next  = head_dec;
              waddr      = head_dec;
              front_next = item.value;
            end else begin
              tail_next = tail_inc;
              waddr     = tail_inc;
              rear_next = item.value;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (!empty) begin
            ok_next     = 1'b1;
            popped_next = (item.cmd == CMD_POP_FRONT) ? front_word : rear_word;
            if (head == tail) begin
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b1;
            end else if (item.cmd == CMD_POP_FRONT) begin
              // fetch the new front word from the ram
              head_next       = head_inc;
              re              = 1'b1;
              raddr           = head_inc;
              load_front_next = 1'b1;
            end else begin
              tail_next      = tail_dec;
              re             = 1'b1;
              raddr          = tail_dec;
              load_rear_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign head_view = load_front ? rdata : front_word;
  assign tail_view = load_rear ? rdata : rear_word;
  assign full_now  = !empty && (tail_inc == head);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            head  <= head_next;
            tail  <= tail_next;
            empty <= empty_next;
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      front_word <= front_next;
      rear_word  <= rear_next;
      ok         <= ok_next;
      popped     <= popped_next;
      load_front <= load_front_next;
      load_rear  <= load_rear_next;
    end else if (busy) begin
      front_word       <= head_view;
      rear_word        <= tail_view;
      result.ok        <= ok;
      result.popped    <= popped;
      result.is_empty  <= empty;
      result.is_full   <= full_now;
      result.head_word <= empty ? '0 : head_view;
      result.tail_word <= empty ? '0 : tail_view;
    end
  end

endmodule
